>>> design/floppy_drive_sector_timing_defines.svh
// Assertion macros shared by the floppy drive sector timing RTL.
`ifndef FLOPPY_DRIVE_SECTOR_TIMING_DEFINES_SVH
`define FLOPPY_DRIVE_SECTOR_TIMING_DEFINES_SVH

`ifndef SYNTH
// Check a property at every clock edge outside reset.
`define FDST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check a property at every clock edge, reset included.
`define FDST_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define FDST_ASSERT(lbl, clk, rst, prop, msg)
`define FDST_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

>>> design/fdst_pkg.sv
// Types, constants and address helper for the floppy drive sector timing block.
package fdst_pkg;

   // Drive geometry
   localparam int TRACK_COUNT      = 77;
   localparam int SECTORS_ON_TRACK = 16;
   localparam int SECTOR_BYTES     = 270;

   // Field and state widths
   localparam int CMD_W    = 4;
   localparam int BYTE_W   = 8;
   localparam int ADDR_W   = 19;
   localparam int COUNT_W  = 16;
   localparam int SECTOR_W = 5;
   localparam int TRACK_W  = 7;
   localparam int INDEX_W  = 9;
   localparam int LIN_W    = 12;
   localparam int PROD_W   = 21;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // Queue between decode and execute
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = 2;
   localparam int QCNT_W      = 3;

   // Typed geometry constants
   localparam logic [TRACK_W-1:0]  TRACK_LAST   = TRACK_W'(TRACK_COUNT - 1);
   localparam logic [SECTOR_W-1:0] SECTOR_LIMIT = SECTOR_W'(SECTORS_ON_TRACK);
   localparam logic [INDEX_W-1:0]  INDEX_LIMIT  = INDEX_W'(SECTOR_BYTES);
   localparam logic [COUNT_W-1:0]  TICKS_RESET  = COUNT_W'(64);
   localparam int STATUS_NEW_BIT = 7;

   // Command codes on the request channel
   localparam logic [CMD_W-1:0] CMD_TICK       = 4'd0;
   localparam logic [CMD_W-1:0] CMD_STEP_IN    = 4'd1;
   localparam logic [CMD_W-1:0] CMD_STEP_OUT   = 4'd2;
   localparam logic [CMD_W-1:0] CMD_READY_WR   = 4'd3;
   localparam logic [CMD_W-1:0] CMD_ACTIVATE   = 4'd4;
   localparam logic [CMD_W-1:0] CMD_DEACTIVATE = 4'd5;
   localparam logic [CMD_W-1:0] CMD_STATUS     = 4'd6;
   localparam logic [CMD_W-1:0] CMD_RD_DATA    = 4'd7;
   localparam logic [CMD_W-1:0] CMD_WR_DATA    = 4'd8;

   // Register indexes on the control port
   localparam logic [CSR_IDX_W-1:0] REG_DISK_INSERTED = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_TICKS  = 2'd1;

   // Decoded operation
   typedef enum logic [3:0] {
      OP_TICK,
      OP_STEP_IN,
      OP_STEP_OUT,
      OP_READY_WR,
      OP_ACTIVATE,
      OP_DEACTIVATE,
      OP_STATUS,
      OP_RD_DATA,
      OP_WR_DATA,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [BYTE_W-1:0]  wbyte;
   } queue_entry_type;

   // Byte address of the first byte of a sector, modulo the address space
   function automatic logic [ADDR_W-1:0] seek_of(input logic [TRACK_W-1:0]  track,
                                                 input logic [SECTOR_W-1:0] sector);
      logic [LIN_W-1:0]  lin;
      logic [PROD_W-1:0] prod;
      lin  = LIN_W'(track) * LIN_W'(SECTORS_ON_TRACK) + LIN_W'(sector);
      prod = PROD_W'(lin) * PROD_W'(SECTOR_BYTES);
      return prod[ADDR_W-1:0];
   endfunction

endpackage

>>> design/fdst_channels.sv
// Channel interfaces: command requests, results and control register writes.
interface fdst_req_if;
   logic                             valid;
   logic                             ready;
   logic [fdst_pkg::CMD_W-1:0]       cmd;
   logic [fdst_pkg::BYTE_W-1:0]      write_byte;
   modport source(output valid, cmd, write_byte, input ready);
   modport sink(input valid, cmd, write_byte, output ready);
endinterface

interface fdst_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fdst_pkg::BYTE_W-1:0]      reg_value;
   logic [fdst_pkg::ADDR_W-1:0]      mem_address;
   logic                             mem_read;
   logic                             mem_write;
   logic [fdst_pkg::BYTE_W-1:0]      mem_wdata;
   logic                             is_active;
   logic                             data_ready;
   logic                             at_home;
   modport source(output valid, reg_value, mem_address, mem_read, mem_write, mem_wdata,
                  is_active, data_ready, at_home, input ready);
   modport sink(input valid, reg_value, mem_address, mem_read, mem_write, mem_wdata,
                is_active, data_ready, at_home, output ready);
endinterface

interface fdst_csr_if;
   logic                             valid;
   logic                             ready;
   logic [fdst_pkg::CSR_IDX_W-1:0]   wr_index;
   logic [fdst_pkg::CSR_DATA_W-1:0]  wr_data;
   modport source(output valid, wr_index, wr_data, input ready);
   modport sink(input valid, wr_index, wr_data, output ready);
endinterface

>>> design/fdst_front.sv
// Command intake: accepts requests and decodes them into queue entries.
module fdst_front (
   fdst_req_if.sink                   req_bus,
   input  logic                       queue_full,
   output logic                       push,
   output fdst_pkg::queue_entry_type  push_entry
);

   fdst_pkg::op_type op;

   // Classify the command code
   always_comb begin
      case (req_bus.cmd)
         fdst_pkg::CMD_TICK:       op = fdst_pkg::OP_TICK;
         fdst_pkg::CMD_STEP_IN:    op = fdst_pkg::OP_STEP_IN;
         fdst_pkg::CMD_STEP_OUT:   op = fdst_pkg::OP_STEP_OUT;
         fdst_pkg::CMD_READY_WR:   op = fdst_pkg::OP_READY_WR;
         fdst_pkg::CMD_ACTIVATE:   op = fdst_pkg::OP_ACTIVATE;
         fdst_pkg::CMD_DEACTIVATE: op = fdst_pkg::OP_DEACTIVATE;
         fdst_pkg::CMD_STATUS:     op = fdst_pkg::OP_STATUS;
         fdst_pkg::CMD_RD_DATA:    op = fdst_pkg::OP_RD_DATA;
         fdst_pkg::CMD_WR_DATA:    op = fdst_pkg::OP_WR_DATA;
         default:                  op = fdst_pkg::OP_NONE;
      endcase
   end

   // Take a transfer whenever the queue has room
   assign req_bus.ready    = !queue_full;
   assign push             = req_bus.valid && !queue_full;
   assign push_entry.op    = op;
   assign push_entry.wbyte = req_bus.write_byte;

endmodule

>>> design/fdst_queue.sv
// Short command queue between decode and execute.
`include "floppy_drive_sector_timing_defines.svh"

module fdst_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  fdst_pkg::queue_entry_type  push_entry,
   input  logic                       pop,
   output logic                       full,
   output logic                       not_empty,
   output fdst_pkg::queue_entry_type  head
);

   fdst_pkg::queue_entry_type entry_ff [fdst_pkg::QUEUE_DEPTH];
   logic [fdst_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [fdst_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [fdst_pkg::QCNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == fdst_pkg::QCNT_W'(fdst_pkg::QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = entry_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store the entry
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `FDST_ASSERT(a_count_in_range, clock, reset, count_ff <= fdst_pkg::QCNT_W'(fdst_pkg::QUEUE_DEPTH), "queue count beyond depth")
   `FDST_ASSERT(a_no_overflow, clock, reset, !(push && full), "push into a full queue")
   `FDST_ASSERT(a_no_underflow, clock, reset, !(pop && !not_empty), "pop from an empty queue")

endmodule

>>> design/fdst_back.sv
// Command execution: drive state, control registers and the result register.
`include "floppy_drive_sector_timing_defines.svh"

module fdst_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       queue_not_empty,
   input  fdst_pkg::queue_entry_type  head,
   output logic                       pop,
   fdst_csr_if.sink                   csr_bus,
   fdst_rsp_if.source                 rsp_bus
);

   // Control registers
   logic                                inserted_ff, inserted_in;
   logic [fdst_pkg::COUNT_W-1:0]        reload_ff, reload_in;
   // Drive state
   logic [fdst_pkg::COUNT_W-1:0]        act_ff, act_in;
   logic [fdst_pkg::SECTOR_W-1:0]       sector_ff, sector_in;
   logic [fdst_pkg::TRACK_W-1:0]        track_ff, track_in;
   logic [fdst_pkg::INDEX_W-1:0]        index_ff, index_in;
   logic                                new_sec_ff, new_sec_in;
   logic                                ready_ff, ready_in;
   logic                                open_ff, open_in;
   logic [fdst_pkg::ADDR_W-1:0]         base_ff, base_in;
   // Result register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [fdst_pkg::BYTE_W-1:0]         reg_value_ff, reg_value_in;
   logic [fdst_pkg::ADDR_W-1:0]         mem_address_ff, mem_address_in;
   logic                                mem_read_ff, mem_read_in;
   logic                                mem_write_ff, mem_write_in;
   logic [fdst_pkg::BYTE_W-1:0]         mem_wdata_ff, mem_wdata_in;
   logic                                is_active_ff, is_active_in;
   logic                                data_ready_ff, data_ready_in;
   logic                                at_home_ff, at_home_in;

   logic                                csr_wr;
   logic                                out_free;
   logic [fdst_pkg::SECTOR_W-1:0]       sec_inc;
   logic [fdst_pkg::COUNT_W-1:0]        act_dec;
   logic [fdst_pkg::COUNT_W-1:0]        act_reload;

   assign csr_bus.ready = 1'b1;
   assign csr_wr        = csr_bus.valid;
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   // Register writes take the cycle; otherwise execute when the result slot frees
   assign pop           = queue_not_empty && out_free && !csr_wr;

   assign sec_inc    = sector_ff + 1'b1;
   assign act_dec    = act_ff - 1'b1;
   assign act_reload = (act_ff != '0) ? reload_ff : act_ff;

   // Next drive state and result fields
   always_comb begin
      inserted_in    = inserted_ff;
      reload_in      = reload_ff;
      act_in         = act_ff;
      sector_in      = sector_ff;
      track_in       = track_ff;
      index_in       = index_ff;
      new_sec_in     = new_sec_ff;
      ready_in       = ready_ff;
      open_in        = open_ff;
      base_in        = base_ff;
      reg_value_in   = '0;
      mem_address_in = '0;
      mem_read_in    = 1'b0;
      mem_write_in   = 1'b0;
      mem_wdata_in   = '0;

      if (csr_wr) begin
         case (csr_bus.wr_index)
            fdst_pkg::REG_DISK_INSERTED: begin
               inserted_in = csr_bus.wr_data[0];
               if (!csr_bus.wr_data[0]) begin
                  act_in     = '0;
                  sector_in  = '0;
                  track_in   = '0;
                  new_sec_in = 1'b0;
                  index_in   = '0;
               end
               open_in  = 1'b0;
               ready_in = 1'b0;
            end
            fdst_pkg::REG_ACTIVE_TICKS: begin
               reload_in = csr_bus.wr_data;
            end
            default: begin
            end
         endcase
      end else if (pop) begin
         case (head.op)
            fdst_pkg::OP_TICK: begin
               if (act_ff != '0) begin
                  if (index_ff != '0 && index_ff < fdst_pkg::INDEX_LIMIT && ready_ff) begin
                     // Data-ready gap in mid-sector
                     sector_in = sec_inc;
                     ready_in  = 1'b0;
                  end else begin
                     ready_in   = 1'b1;
                     index_in   = '0;
                     sector_in  = (sec_inc >= fdst_pkg::SECTOR_LIMIT) ? '0 : sec_inc;
                     new_sec_in = 1'b1;
                     if (act_dec == '0) begin
                        open_in    = 1'b0;
                        act_in     = '0;
                        sector_in  = '0;
                        track_in   = '0;
                        new_sec_in = 1'b0;
                        ready_in   = 1'b0;
                     end else begin
                        act_in = act_dec;
                        if (open_ff) begin
                           base_in = fdst_pkg::seek_of(track_ff,
                              (sec_inc >= fdst_pkg::SECTOR_LIMIT) ? '0 : sec_inc);
                        end
                     end
                  end
               end
            end
            fdst_pkg::OP_STEP_IN: begin
               ready_in = 1'b0;
               index_in = '0;
               act_in   = act_reload;
               if (track_ff < fdst_pkg::TRACK_LAST) begin
                  track_in = track_ff + 1'b1;
               end
            end
            fdst_pkg::OP_STEP_OUT: begin
               ready_in = 1'b0;
               index_in = '0;
               act_in   = act_reload;
               if (track_ff != '0) begin
                  track_in = track_ff - 1'b1;
               end
            end
            fdst_pkg::OP_READY_WR: begin
               act_in = act_reload;
            end
            fdst_pkg::OP_ACTIVATE: begin
               ready_in  = 1'b0;
               index_in  = '0;
               sector_in = '0;
               if (inserted_ff && act_ff == '0) begin
                  open_in = 1'b1;
                  act_in  = reload_ff;
                  base_in = fdst_pkg::seek_of(track_ff, '0);
               end
            end
            fdst_pkg::OP_DEACTIVATE: begin
               open_in    = 1'b0;
               act_in     = '0;
               sector_in  = '0;
               track_in   = '0;
               new_sec_in = 1'b0;
               ready_in   = 1'b0;
               index_in   = '0;
            end
            fdst_pkg::OP_STATUS: begin
               act_in       = act_reload;
               reg_value_in = fdst_pkg::BYTE_W'(sector_ff);
               if (new_sec_ff) begin
                  reg_value_in[fdst_pkg::STATUS_NEW_BIT] = 1'b1;
                  new_sec_in = 1'b0;
               end
            end
            fdst_pkg::OP_RD_DATA, fdst_pkg::OP_WR_DATA: begin
               act_in = act_reload;
               if (inserted_ff && open_ff && index_ff < fdst_pkg::INDEX_LIMIT) begin
                  mem_address_in = base_ff + fdst_pkg::ADDR_W'(index_ff);
                  if (head.op == fdst_pkg::OP_RD_DATA) begin
                     mem_read_in = 1'b1;
                  end else begin
                     mem_write_in = 1'b1;
                     mem_wdata_in = head.wbyte;
                  end
                  index_in = index_ff + 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      is_active_in  = (act_in != '0);
      data_ready_in = ready_in;
      at_home_in    = (track_in == '0);
   end

   // Hold the result until taken, load a new one on each executed command
   always_comb begin
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inserted_ff  <= 1'b0;
         reload_ff    <= fdst_pkg::TICKS_RESET;
         act_ff       <= '0;
         sector_ff    <= '0;
         track_ff     <= '0;
         index_ff     <= '0;
         new_sec_ff   <= 1'b0;
         ready_ff     <= 1'b0;
         open_ff      <= 1'b0;
         base_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         inserted_ff  <= inserted_in;
         reload_ff    <= reload_in;
         act_ff       <= act_in;
         sector_ff    <= sector_in;
         track_ff     <= track_in;
         index_ff     <= index_in;
         new_sec_ff   <= new_sec_in;
         ready_ff     <= ready_in;
         open_ff      <= open_in;
         base_ff      <= base_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (pop) begin
         reg_value_ff   <= reg_value_in;
         mem_address_ff <= mem_address_in;
         mem_read_ff    <= mem_read_in;
         mem_write_ff   <= mem_write_in;
         mem_wdata_ff   <= mem_wdata_in;
         is_active_ff   <= is_active_in;
         data_ready_ff  <= data_ready_in;
         at_home_ff     <= at_home_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.reg_value   = reg_value_ff;
   assign rsp_bus.mem_address = mem_address_ff;
   assign rsp_bus.mem_read    = mem_read_ff;
   assign rsp_bus.mem_write   = mem_write_ff;
   assign rsp_bus.mem_wdata   = mem_wdata_ff;
   assign rsp_bus.is_active   = is_active_ff;
   assign rsp_bus.data_ready  = data_ready_ff;
   assign rsp_bus.at_home     = at_home_ff;

   `FDST_ASSERT(a_track_in_range, clock, reset, track_ff <= fdst_pkg::TRACK_LAST, "track beyond last")
   `FDST_ASSERT(a_index_in_range, clock, reset, index_ff <= fdst_pkg::INDEX_LIMIT, "byte index past sector end")
   `FDST_ASSERT(a_rd_wr_exclusive, clock, reset, !(rsp_valid_ff && mem_read_ff && mem_write_ff), "read and write in one result")

endmodule

>>> design/floppy_drive_sector_timing.sv
// Top level of the floppy drive sector timing block.
//
//  channel   dir  handshake      payload
//  req_bus   in   valid/ready    cmd, write_byte
//  rsp_bus   out  valid/ready    reg_value, mem_address, mem_read, mem_write,
//                                mem_wdata, is_active, data_ready, at_home
//  csr_bus   in   valid/ready    wr_index, wr_data
//
// One command per cycle while the queue has room and neither a register write nor a
// stalled result holds execute; a result is registered in the cycle after its command
// leaves the four-entry queue. The execute stage updates all drive state per command.
// A register write takes the execute stage for its cycle; csr_bus.ready is always high.
// Synchronous reset clears drive state, reload ticks go to 64; no clearing pass needed.
// A stalled result holds in the output register while the queue keeps accepting.
module floppy_drive_sector_timing (
   input  logic         clock,
   input  logic         reset,
   fdst_req_if.sink     req_bus,
   fdst_rsp_if.source   rsp_bus,
   fdst_csr_if.sink     csr_bus
);

   logic                       push;
   logic                       pop;
   logic                       queue_full;
   logic                       queue_not_empty;
   fdst_pkg::queue_entry_type  push_entry;
   fdst_pkg::queue_entry_type  head;

   fdst_front u_front (
      .req_bus    (req_bus),
      .queue_full (queue_full),
      .push       (push),
      .push_entry (push_entry)
   );

   fdst_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (queue_full),
      .not_empty  (queue_not_empty),
      .head       (head)
   );

   fdst_back u_back (
      .clock           (clock),
      .reset           (reset),
      .queue_not_empty (queue_not_empty),
      .head            (head),
      .pop             (pop),
      .csr_bus         (csr_bus),
      .rsp_bus         (rsp_bus)
   );

endmodule

>>> dv/floppy_drive_sector_timing_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the floppy drive sector timing block.
module floppy_drive_sector_timing_tb;

   localparam logic [fdst_pkg::CMD_W-1:0] CMD_UNUSED_FIRST = 4'd9;
   localparam logic [fdst_pkg::CMD_W-1:0] CMD_UNUSED_LAST  = 4'd15;
   localparam int RESET_CYCLES = 12;
   localparam int QUIET_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 8;

   typedef struct {
      logic [fdst_pkg::CMD_W-1:0]  cmd;
      logic [fdst_pkg::BYTE_W-1:0] wbyte;
   } drive_cmd_type;

   typedef struct {
      logic [fdst_pkg::BYTE_W-1:0] reg_value;
      logic [fdst_pkg::ADDR_W-1:0] mem_address;
      logic                        mem_read;
      logic                        mem_write;
      logic [fdst_pkg::BYTE_W-1:0] mem_wdata;
      logic                        is_active;
      logic                        data_ready;
      logic                        at_home;
   } drive_result_type;

   logic clock;
   logic reset;

   fdst_req_if req_bus ();
   fdst_rsp_if rsp_bus ();
   fdst_csr_if csr_bus ();

   floppy_drive_sector_timing i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // Commands waiting to go out and results still owed by the drive
   drive_cmd_type    pending_cmds[$];
   drive_result_type expected_results[$];

   int send_idle_pct;
   int recv_stall_pct;
   int mismatch_count;
   int result_count;
   int quiet_cycles;
   int hold_left;
   logic hold_start;

   // Drive state as the predictor sees it
   logic                          disk_in;
   logic [fdst_pkg::COUNT_W-1:0]  reload_ticks;
   logic [fdst_pkg::COUNT_W-1:0]  act_count;
   logic [fdst_pkg::SECTOR_W-1:0] sector;
   logic [fdst_pkg::TRACK_W-1:0]  track;
   logic [fdst_pkg::INDEX_W-1:0]  byte_idx;
   logic                          new_sector;
   logic                          data_rdy;
   logic                          img_open;
   logic [fdst_pkg::ADDR_W-1:0]   seek_base;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      $display("MISMATCH: %s", msg);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
                                   result_count, name, got, want));
      end
   endtask

   // Spin the drive down and home the head
   function automatic void park_drive();
      img_open   = 1'b0;
      act_count  = '0;
      sector     = '0;
      track      = '0;
      new_sector = 1'b0;
      data_rdy   = 1'b0;
      byte_idx   = '0;
   endfunction

   function automatic void latch_seek_base();
      if (img_open) begin
         seek_base = fdst_pkg::ADDR_W'((int'(track) * fdst_pkg::SECTORS_ON_TRACK +
                                        int'(sector)) * fdst_pkg::SECTOR_BYTES);
      end
   endfunction

   // An access keeps a spinning drive alive but never starts an idle one
   function automatic void refresh_countdown();
      if (act_count != '0) begin
         act_count = reload_ticks;
      end
   endfunction

   function automatic drive_result_type predict_drive(input drive_cmd_type c);
      drive_result_type r;
      r = '{default: '0};
      case (c.cmd)
         fdst_pkg::CMD_TICK: begin
            if (act_count != '0) begin
               sector = sector + 1'b1;
               // A tick in mid-sector with data pending advances the sector and drops the ready flag
               if (byte_idx != '0 && byte_idx < fdst_pkg::INDEX_LIMIT && data_rdy) begin
                  data_rdy = 1'b0;
               end else begin
                  data_rdy = 1'b1;
                  byte_idx = '0;
                  if (sector >= fdst_pkg::SECTOR_LIMIT) begin
                     sector = '0;
                  end
                  new_sector = 1'b1;
                  act_count  = act_count - 1'b1;
                  if (act_count == '0) begin
                     park_drive();
                  end else begin
                     latch_seek_base();
                  end
               end
            end
         end
         fdst_pkg::CMD_STEP_IN, fdst_pkg::CMD_STEP_OUT: begin
            data_rdy = 1'b0;
            byte_idx = '0;
            refresh_countdown();
            if (c.cmd == fdst_pkg::CMD_STEP_IN) begin
               if (track < fdst_pkg::TRACK_LAST) begin
                  track = track + 1'b1;
               end
            end else if (track != '0) begin
               track = track - 1'b1;
            end
         end
         fdst_pkg::CMD_READY_WR: begin
            refresh_countdown();
         end
         fdst_pkg::CMD_ACTIVATE: begin
            data_rdy = 1'b0;
            byte_idx = '0;
            sector   = '0;
            if (disk_in && act_count == '0) begin
               img_open  = 1'b1;
               act_count = reload_ticks;
               latch_seek_base();
            end
         end
         fdst_pkg::CMD_DEACTIVATE: begin
            park_drive();
         end
         fdst_pkg::CMD_STATUS: begin
            refresh_countdown();
            r.reg_value = fdst_pkg::BYTE_W'(sector);
            if (new_sector) begin
               r.reg_value[fdst_pkg::STATUS_NEW_BIT] = 1'b1;
               new_sector = 1'b0;
            end
         end
         fdst_pkg::CMD_RD_DATA, fdst_pkg::CMD_WR_DATA: begin
            refresh_countdown();
            if (disk_in && img_open && byte_idx < fdst_pkg::INDEX_LIMIT) begin
               r.mem_address = seek_base + fdst_pkg::ADDR_W'(byte_idx);
               if (c.cmd == fdst_pkg::CMD_RD_DATA) begin
                  r.mem_read = 1'b1;
               end else begin
                  r.mem_write = 1'b1;
                  r.mem_wdata = c.wbyte;
               end
               byte_idx = byte_idx + 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.is_active  = (act_count != '0);
      r.data_ready = data_rdy;
      r.at_home    = (track == '0);
      return r;
   endfunction

   // Write one control register and mirror it into the predictor
   task automatic write_reg(input logic [fdst_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fdst_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_bus.valid    <= 1'b1;
      csr_bus.wr_index <= idx;
      csr_bus.wr_data  <= value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      case (idx)
         fdst_pkg::REG_DISK_INSERTED: begin
            disk_in = value[0];
            if (!disk_in) begin
               park_drive();
            end
            img_open = 1'b0;
            data_rdy = 1'b0;
         end
         fdst_pkg::REG_ACTIVE_TICKS: begin
            reload_ticks = value;
         end
         default: begin
         end
      endcase
      csr_bus.valid <= 1'b0;
   endtask

   task automatic set_phase(input logic disk, input logic [fdst_pkg::CSR_DATA_W-1:0] ticks,
                            input int idle_pct, input int stall_pct);
      write_reg(fdst_pkg::REG_DISK_INSERTED, fdst_pkg::CSR_DATA_W'(disk));
      write_reg(fdst_pkg::REG_ACTIVE_TICKS, ticks);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
   endtask

   task automatic add_cmd(input logic [fdst_pkg::CMD_W-1:0] cmd,
                          input logic [fdst_pkg::BYTE_W-1:0] wbyte);
      drive_cmd_type c;
      c.cmd   = cmd;
      c.wbyte = wbyte;
      pending_cmds.push_back(c);
   endtask

   // Random mix of spin-up, seek, sector access, tick and status sequences, with some noise mixed in
   task automatic add_random_traffic(input int n);
      int made;
      int len;
      int pick;
      logic [fdst_pkg::CMD_W-1:0] step_cmd;
      made = 0;
      while (made < n) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            if ($urandom_range(3) == 0) begin
               add_cmd(fdst_pkg::CMD_DEACTIVATE, fdst_pkg::BYTE_W'($urandom_range(255)));
               made++;
            end
            add_cmd(fdst_pkg::CMD_ACTIVATE, fdst_pkg::BYTE_W'($urandom_range(255)));
            made++;
         end else if (pick < 15) begin
            if ($urandom_range(14) == 0) begin
               len      = $urandom_range(90, 80);
               step_cmd = fdst_pkg::CMD_STEP_IN;
            end else begin
               len      = $urandom_range(6, 1);
               step_cmd = $urandom_range(1) ? fdst_pkg::CMD_STEP_IN : fdst_pkg::CMD_STEP_OUT;
            end
            repeat (len) add_cmd(step_cmd, fdst_pkg::BYTE_W'($urandom_range(255)));
            made += len;
         end else if (pick < 40) begin
            len = ($urandom_range(39) == 0) ? $urandom_range(285, 265) : $urandom_range(20, 1);
            repeat (len) begin
               add_cmd($urandom_range(1) ? fdst_pkg::CMD_RD_DATA : fdst_pkg::CMD_WR_DATA,
                       fdst_pkg::BYTE_W'($urandom_range(255)));
            end
            made += len;
         end else if (pick < 62) begin
            add_cmd(fdst_pkg::CMD_TICK, fdst_pkg::BYTE_W'($urandom_range(255)));
            made++;
         end else if (pick < 75) begin
            add_cmd(fdst_pkg::CMD_STATUS, fdst_pkg::BYTE_W'($urandom_range(255)));
            made++;
         end else if (pick < 80) begin
            add_cmd(fdst_pkg::CMD_READY_WR, fdst_pkg::BYTE_W'($urandom_range(255)));
            made++;
         end else if (pick < 83) begin
            add_cmd(fdst_pkg::CMD_DEACTIVATE, fdst_pkg::BYTE_W'($urandom_range(255)));
            made++;
         end else if (pick < 87) begin
            add_cmd(fdst_pkg::CMD_W'($urandom_range(CMD_UNUSED_LAST, CMD_UNUSED_FIRST)),
                    fdst_pkg::BYTE_W'($urandom_range(255)));
         end else begin
            add_cmd(fdst_pkg::CMD_TICK, fdst_pkg::BYTE_W'($urandom_range(255)));
            add_cmd(fdst_pkg::CMD_STATUS, fdst_pkg::BYTE_W'($urandom_range(255)));
            made += 2;
         end
      end
   endtask

   // Hold until every command went out and every result came back
   task automatic wait_drained();
      do @(posedge clock);
      while (pending_cmds.size() != 0 || req_bus.valid || expected_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic kick_hold();
      @(posedge clock);
      hold_start <= 1'b1;
      @(posedge clock);
      hold_start <= 1'b0;
   endtask

   // Present commands and predict each one on its transfer
   always @(posedge clock) begin : drive_proc
      drive_cmd_type seen;
      drive_cmd_type nxt;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            seen.cmd   = req_bus.cmd;
            seen.wbyte = req_bus.write_byte;
            expected_results.push_back(predict_drive(seen));
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (pending_cmds.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = pending_cmds.pop_front();
               req_bus.valid      <= 1'b1;
               req_bus.cmd        <= nxt.cmd;
               req_bus.write_byte <= nxt.wbyte;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Compare each result transfer against the oldest prediction
   always @(posedge clock) begin : check_proc
      drive_result_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            result_count++;
            if (expected_results.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with nothing expected",
                                         result_count));
            end else begin
               want = expected_results.pop_front();
               check_field("reg_value", rsp_bus.reg_value, want.reg_value);
               check_field("mem_address", rsp_bus.mem_address, want.mem_address);
               check_field("mem_read", rsp_bus.mem_read, want.mem_read);
               check_field("mem_write", rsp_bus.mem_write, want.mem_write);
               check_field("mem_wdata", rsp_bus.mem_wdata, want.mem_wdata);
               check_field("is_active", rsp_bus.is_active, want.is_active);
               check_field("data_ready", rsp_bus.data_ready, want.data_ready);
               check_field("at_home", rsp_bus.at_home, want.at_home);
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Count down a long receiver hold-off
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_start) begin
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Abort when no transfer of any kind happens for too long
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
                   (csr_bus.valid && csr_bus.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TIMEOUT: no transfer for %0d cycles", quiet_cycles);
         $display("end of test: mismatches");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = '0;
      req_bus.write_byte = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.wr_index   = '0;
      csr_bus.wr_data    = '0;
      hold_start         = 1'b0;
      send_idle_pct      = 0;
      recv_stall_pct     = 0;
      mismatch_count     = 0;
      result_count       = 0;
      disk_in            = 1'b0;
      reload_ticks       = fdst_pkg::TICKS_RESET;
      park_drive();
      seek_base          = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: idle drive, spin-up, sector access, seeks and spin-down
      set_phase(1'b1, 16'd3, 0, 0);
      add_cmd(CMD_UNUSED_LAST, 8'h00);
      add_cmd(fdst_pkg::CMD_RD_DATA, 8'h00);
      add_cmd(fdst_pkg::CMD_TICK, 8'h00);
      add_cmd(fdst_pkg::CMD_STATUS, 8'h00);
      add_cmd(fdst_pkg::CMD_STEP_OUT, 8'h00);
      add_cmd(fdst_pkg::CMD_ACTIVATE, 8'h00);
      add_cmd(fdst_pkg::CMD_ACTIVATE, 8'h00);
      add_cmd(fdst_pkg::CMD_WR_DATA, 8'hff);
      add_cmd(fdst_pkg::CMD_RD_DATA, 8'h00);
      add_cmd(fdst_pkg::CMD_WR_DATA, 8'h00);
      add_cmd(fdst_pkg::CMD_TICK, 8'h00);
      add_cmd(fdst_pkg::CMD_RD_DATA, 8'h00);
      add_cmd(fdst_pkg::CMD_TICK, 8'h00);
      add_cmd(fdst_pkg::CMD_STATUS, 8'h00);
      add_cmd(fdst_pkg::CMD_STATUS, 8'h00);
      add_cmd(fdst_pkg::CMD_STEP_IN, 8'h00);
      add_cmd(fdst_pkg::CMD_STEP_IN, 8'h00);
      add_cmd(fdst_pkg::CMD_STEP_OUT, 8'h00);
      add_cmd(fdst_pkg::CMD_READY_WR, 8'h00);
      add_cmd(fdst_pkg::CMD_TICK, 8'h00);
      add_cmd(fdst_pkg::CMD_TICK, 8'h00);
      add_cmd(fdst_pkg::CMD_TICK, 8'h00);
      add_cmd(fdst_pkg::CMD_RD_DATA, 8'h00);
      add_cmd(fdst_pkg::CMD_DEACTIVATE, 8'h00);
      add_cmd(CMD_UNUSED_FIRST, 8'hff);
      wait_drained();

      set_phase(1'b1, 16'd64, 0, 0);
      add_random_traffic(90);
      wait_drained();

      set_phase(1'b1, 16'd1, 55, 0);
      add_random_traffic(70);
      wait_drained();

      // No disk: nothing may open or spin
      set_phase(1'b0, 16'd5, 0, 55);
      add_random_traffic(60);
      wait_drained();

      // Long countdown: run a whole sector past its end and seek to the last track
      set_phase(1'b1, 16'hffff, 24, 24);
      add_cmd(fdst_pkg::CMD_ACTIVATE, 8'h00);
      repeat (280) begin
         add_cmd($urandom_range(1) ? fdst_pkg::CMD_RD_DATA : fdst_pkg::CMD_WR_DATA,
                 fdst_pkg::BYTE_W'($urandom_range(255)));
      end
      repeat (80) add_cmd(fdst_pkg::CMD_STEP_IN, fdst_pkg::BYTE_W'($urandom_range(255)));
      add_cmd(fdst_pkg::CMD_TICK, 8'h00);
      add_cmd(fdst_pkg::CMD_RD_DATA, 8'h00);
      add_random_traffic(30);
      wait_drained();

      // Zero reload value keeps the drive idle after activation
      set_phase(1'b1, 16'd0, 0, 0);
      add_random_traffic(40);
      wait_drained();

      // Back up the result side while commands keep coming
      set_phase(1'b1, 16'd7, 0, 0);
      add_random_traffic(80);
      kick_hold();
      wait_drained();

      set_phase(1'b1, 16'd20, 24, 24);
      add_random_traffic(80);
      wait_drained();

      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
